### rtl/mcu_pkg.sv
// Shared types and constants for the motion-compensated update block.
package mcu_pkg;

    // Command codes carried by an input transaction.
    typedef enum logic [1:0] {
        OP_WRITE  = 2'd0,
        OP_UPDATE = 2'd1,
        OP_READ   = 2'd2
    } op_t;

    // Configuration register indexes.
    typedef enum logic [1:0] {
        CFG_WIDTH    = 2'd0,
        CFG_HEIGHT   = 2'd1,
        CFG_WEIGHT   = 2'd2,
        CFG_ADD_MODE = 2'd3
    } cfg_idx_t;

    // Controller states.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ADDR,
        ST_WRITE,
        ST_READ,
        ST_READ_WAIT,
        ST_UPD_PREV,
        ST_UPD_MID,
        ST_UPD_NEXT,
        ST_DONE
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;     // latch the accepted transaction
        logic calc;        // form addresses and weighted residue
        logic mem_write;   // plain pixel write
        logic read_issue;  // plain pixel read, address phase
        logic read_take;   // plain pixel read, data phase
        logic rd_prev;     // update: read previous picture
        logic mid;         // update: write previous, read next
        logic wr_next;     // update: write next picture
        logic load_out;    // move results into the output register
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        op_t  op;
        logic comp_ok;
    } dp_status_t;

    // Reset values of the configuration registers.
    localparam logic [7:0] RST_WIDTH    = 8'd128;
    localparam logic [7:0] RST_HEIGHT   = 8'd128;
    localparam logic [8:0] RST_WEIGHT   = 9'd64;
    localparam logic       RST_ADD_MODE = 1'b0;

    // Saturation bound of pixel * 256.
    localparam logic signed [20:0] SUM_MAX = 21'sd65280;
    localparam logic [7:0]         PIX_MAX = 8'd255;

endpackage

### rtl/mcu_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module mcu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### rtl/mcu_ctrl.sv
// Controller state machine that sequences writes, reads and updates.
module mcu_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    output logic                 out_valid,
    input  logic                 out_ready,
    input  mcu_pkg::dp_status_t  status,
    output mcu_pkg::dp_cmd_t     dp_cmd
);
    import mcu_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    // State and output-valid registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Next state and datapath commands.
    always_comb
    begin
        dp_cmd     = '0;
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    dp_cmd.capture = 1'b1;
                    state_next     = ST_ADDR;
                end
            end
            ST_ADDR:
            begin
                dp_cmd.calc = 1'b1;
                unique case (status.op)
                    OP_WRITE:  state_next = ST_WRITE;
                    OP_READ:   state_next = ST_READ;
                    OP_UPDATE: state_next = status.comp_ok ? ST_UPD_PREV : ST_DONE;
                    default:   state_next = ST_DONE;
                endcase
            end
            ST_WRITE:
            begin
                dp_cmd.mem_write = 1'b1;
                state_next       = ST_DONE;
            end
            ST_READ:
            begin
                dp_cmd.read_issue = 1'b1;
                state_next        = ST_READ_WAIT;
            end
            ST_READ_WAIT:
            begin
                dp_cmd.read_take = 1'b1;
                state_next       = ST_DONE;
            end
            ST_UPD_PREV:
            begin
                dp_cmd.rd_prev = 1'b1;
                state_next     = ST_UPD_MID;
            end
            ST_UPD_MID:
            begin
                dp_cmd.mid = 1'b1;
                state_next = ST_UPD_NEXT;
            end
            ST_UPD_NEXT:
            begin
                dp_cmd.wr_next = 1'b1;
                state_next     = ST_DONE;
            end
            ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    dp_cmd.load_out = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // The output register is refilled or drained.
    always_comb
    begin
        if (dp_cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;

endmodule

### rtl/mcu_datapath.sv
// Datapath: configuration registers, address clamping, weighting and frame memory.
module mcu_datapath #(
    parameter int MAX_WIDTH      = 128,
    parameter int MAX_HEIGHT     = 128,
    parameter int NUM_COMPONENTS = 3
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_valid,
    input  logic [1:0]          cfg_index,
    input  logic [8:0]          cfg_data,
    input  logic [1:0]          cmd,
    input  logic                picture,
    input  logic [1:0]          component,
    input  logic [6:0]          row,
    input  logic [6:0]          col,
    input  logic [7:0]          pixel_value,
    input  logic signed [8:0]   residue,
    input  logic signed [7:0]   mv_prev_y,
    input  logic signed [7:0]   mv_prev_x,
    input  logic signed [7:0]   mv_next_y,
    input  logic signed [7:0]   mv_next_x,
    input  mcu_pkg::dp_cmd_t    dp_cmd,
    output mcu_pkg::dp_status_t status,
    output logic [7:0]          read_value,
    output logic [7:0]          prev_new,
    output logic [7:0]          next_new
);
    import mcu_pkg::*;

    localparam int XW    = $clog2(MAX_WIDTH);
    localparam int YW    = $clog2(MAX_HEIGHT);
    localparam int PLW   = $clog2(2 * NUM_COMPONENTS);
    localparam int AW    = PLW + YW + XW;
    localparam int DEPTH = 2 * NUM_COMPONENTS * (2 ** (YW + XW));
    localparam int WCAP  = (MAX_WIDTH > 255) ? 255 : MAX_WIDTH;
    localparam int HCAP  = (MAX_HEIGHT > 255) ? 255 : MAX_HEIGHT;

    // Configuration registers.
    logic [7:0] frame_width_reg;
    logic [7:0] frame_height_reg;
    logic [8:0] update_weight_reg;
    logic       add_mode_reg;

    // Captured transaction.
    op_t               op_reg;
    logic              pic_reg;
    logic [1:0]        comp_reg;
    logic [6:0]        row_reg;
    logic [6:0]        col_reg;
    logic [7:0]        pix_reg;
    logic signed [8:0] res_reg;
    logic signed [7:0] mvpy_reg;
    logic signed [7:0] mvpx_reg;
    logic signed [7:0] mvny_reg;
    logic signed [7:0] mvnx_reg;

    // Address and weighting stage.
    logic [AW-1:0]      addr_a_reg;
    logic [AW-1:0]      addr_p_reg;
    logic [AW-1:0]      addr_n_reg;
    logic signed [18:0] prod_reg;

    // Working and output results.
    logic [7:0] rd_work_reg;
    logic [7:0] prev_work_reg;
    logic [7:0] next_work_reg;
    logic [7:0] read_value_reg;
    logic [7:0] prev_new_reg;
    logic [7:0] next_new_reg;

    logic [7:0]    fw_nz;
    logic [7:0]    fh_nz;
    logic [7:0]    eff_w;
    logic [7:0]    eff_h;
    logic          comp_ok;
    logic          in_frame;
    logic          access_ok;
    logic          ram_wr_en;
    logic [AW-1:0] ram_wr_addr;
    logic [7:0]    ram_wr_data;
    logic          ram_rd_en;
    logic [AW-1:0] ram_rd_addr;
    logic [7:0]    ram_q;
    logic [7:0]    upd_value;

    // Clamp base plus signed offset into 0..dim-1.
    function automatic logic [7:0] clamp_pos(input logic [6:0] base,
                                             input logic signed [7:0] off,
                                             input logic [7:0] dim);
        logic signed [9:0] v;
        logic [7:0]        r;
        v = $signed({3'b000, base}) + $signed({{2{off[7]}}, off});
        if (v < 10'sd0)
        begin
            r = 8'd0;
        end
        else if (v >= $signed({2'b00, dim}))
        begin
            r = dim - 8'd1;
        end
        else
        begin
            r = v[7:0];
        end
        return r;
    endfunction

    // Plane index of a picture and component.
    function automatic logic [PLW-1:0] plane_of(input logic pic, input logic [1:0] comp);
        logic [PLW-1:0] base;
        base = pic ? PLW'(NUM_COMPONENTS) : '0;
        return base + PLW'(comp);
    endfunction

    // Pixel * 256 plus or minus weighted residue, saturated and floored.
    function automatic logic [7:0] apply_update(input logic [7:0] pix,
                                                input logic signed [18:0] d,
                                                input logic add);
        logic signed [20:0] s;
        logic signed [20:0] dx;
        logic [7:0]         r;
        s  = $signed({5'b00000, pix, 8'h00});
        dx = $signed({{2{d[18]}}, d});
        s  = add ? (s + dx) : (s - dx);
        if (s < 21'sd0)
        begin
            r = 8'd0;
        end
        else if (s > SUM_MAX)
        begin
            r = PIX_MAX;
        end
        else
        begin
            r = s[15:8];
        end
        return r;
    endfunction

    // Configuration register writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg   <= RST_WIDTH;
            frame_height_reg  <= RST_HEIGHT;
            update_weight_reg <= RST_WEIGHT;
            add_mode_reg      <= RST_ADD_MODE;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_WIDTH:    frame_width_reg   <= cfg_data[7:0];
                CFG_HEIGHT:   frame_height_reg  <= cfg_data[7:0];
                CFG_WEIGHT:   update_weight_reg <= cfg_data;
                CFG_ADD_MODE: add_mode_reg      <= cfg_data[0];
                default:      ;
            endcase
        end
    end

    // Effective frame size: zero acts as one, capped at the maximum frame size.
    always_comb
    begin
        fw_nz = (frame_width_reg == 8'd0) ? 8'd1 : frame_width_reg;
        fh_nz = (frame_height_reg == 8'd0) ? 8'd1 : frame_height_reg;
        eff_w = (fw_nz > 8'(WCAP)) ? 8'(WCAP) : fw_nz;
        eff_h = (fh_nz > 8'(HCAP)) ? 8'(HCAP) : fh_nz;
    end

    assign comp_ok   = ({1'b0, comp_reg} < 3'(NUM_COMPONENTS));
    assign in_frame  = ({1'b0, row_reg} < eff_h) && ({1'b0, col_reg} < eff_w);
    assign access_ok = comp_ok && in_frame;

    assign status.op      = op_reg;
    assign status.comp_ok = comp_ok;

    // Transaction capture.
    always_ff @(posedge clk)
    begin
        if (dp_cmd.capture)
        begin
            op_reg   <= op_t'(cmd);
            pic_reg  <= picture;
            comp_reg <= component;
            row_reg  <= row;
            col_reg  <= col;
            pix_reg  <= pixel_value;
            res_reg  <= residue;
            mvpy_reg <= mv_prev_y;
            mvpx_reg <= mv_prev_x;
            mvny_reg <= mv_next_y;
            mvnx_reg <= mv_next_x;
        end
    end

    // Addresses of the accessed, previous and next pixels, and the weighted residue shared by both pictures.
    always_ff @(posedge clk)
    begin
        if (dp_cmd.calc)
        begin
            addr_a_reg <= {plane_of(pic_reg, comp_reg), YW'(row_reg), XW'(col_reg)};
            addr_p_reg <= {plane_of(1'b0, comp_reg),
                           YW'(clamp_pos(row_reg, mvpy_reg, eff_h)),
                           XW'(clamp_pos(col_reg, mvpx_reg, eff_w))};
            addr_n_reg <= {plane_of(1'b1, comp_reg),
                           YW'(clamp_pos(row_reg, mvny_reg, eff_h)),
                           XW'(clamp_pos(col_reg, mvnx_reg, eff_w))};
            prod_reg   <= 19'(res_reg) * 19'($signed({1'b0, update_weight_reg}));
        end
    end

    // Memory port steering.
    assign upd_value = apply_update(ram_q, prod_reg, add_mode_reg);

    always_comb
    begin
        ram_rd_en   = dp_cmd.read_issue || dp_cmd.rd_prev || dp_cmd.mid;
        ram_rd_addr = dp_cmd.rd_prev ? addr_p_reg : (dp_cmd.mid ? addr_n_reg : addr_a_reg);
        ram_wr_en   = (dp_cmd.mem_write && access_ok) || dp_cmd.mid || dp_cmd.wr_next;
        ram_wr_addr = dp_cmd.mem_write ? addr_a_reg : (dp_cmd.mid ? addr_p_reg : addr_n_reg);
        ram_wr_data = dp_cmd.mem_write ? pix_reg : upd_value;
    end

    mcu_ram #(
        .WIDTH (8),
        .DEPTH (DEPTH)
    ) u_frame_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_q)
    );

    // Working results: cleared per transaction, then filled by the sequence.
    always_ff @(posedge clk)
    begin
        if (dp_cmd.capture)
        begin
            rd_work_reg   <= 8'd0;
            prev_work_reg <= 8'd0;
            next_work_reg <= 8'd0;
        end
        if (dp_cmd.read_take)
        begin
            rd_work_reg <= access_ok ? ram_q : 8'd0;
        end
        if (dp_cmd.mid)
        begin
            prev_work_reg <= upd_value;
        end
        if (dp_cmd.wr_next)
        begin
            next_work_reg <= upd_value;
        end
    end

    // Output register.
    always_ff @(posedge clk)
    begin
        if (dp_cmd.load_out)
        begin
            read_value_reg <= rd_work_reg;
            prev_new_reg   <= prev_work_reg;
            next_new_reg   <= next_work_reg;
        end
    end

    assign read_value = read_value_reg;
    assign prev_new   = prev_new_reg;
    assign next_new   = next_new_reg;

endmodule

### rtl/mctf_motion_compensated_update.sv
// Top level of the motion-compensated temporal update block.
//
// Channels: the input channel (in_valid/in_ready) carries one command per
// transaction: write a reference pixel, read one back, or update both
// reference pictures with a weighted residue at motion-shifted positions.
// The output channel (out_valid/out_ready) returns one result per command.
// The configuration channel (cfg_valid/cfg_ready) is always ready and writes
// frame width, frame height, update weight and add mode by index.
// Timing: one command at a time. After the address state a write passes the
// write state, a read the read and read-wait states, an update the three
// update states; each ends in the done state, where the result moves into
// the output register. The update sequence is set by the frame memory: one
// registered read and one write per cycle, two read-modify-writes per update.
// Reset clears the controller and loads the configuration defaults; the
// frame memory is not cleared and a pixel reads back only after it was
// written. A stalled receiver holds the result in the output register; the
// next command is still accepted and runs up to its result, then waits.
module mctf_motion_compensated_update #(
    parameter int MAX_WIDTH      = 128,
    parameter int MAX_HEIGHT     = 128,
    parameter int NUM_COMPONENTS = 3
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [1:0]        cfg_index,
    input  logic [8:0]        cfg_data,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [1:0]        cmd,
    input  logic              picture,
    input  logic [1:0]        component,
    input  logic [6:0]        row,
    input  logic [6:0]        col,
    input  logic [7:0]        pixel_value,
    input  logic signed [8:0] residue,
    input  logic signed [7:0] mv_prev_y,
    input  logic signed [7:0] mv_prev_x,
    input  logic signed [7:0] mv_next_y,
    input  logic signed [7:0] mv_next_x,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [7:0]        read_value,
    output logic [7:0]        prev_new,
    output logic [7:0]        next_new
);
    import mcu_pkg::*;

    dp_cmd_t    dp_cmd;
    dp_status_t dp_status;

    // The configuration channel is always ready.
    assign cfg_ready = 1'b1;

    mcu_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (dp_status),
        .dp_cmd    (dp_cmd)
    );

    mcu_datapath #(
        .MAX_WIDTH      (MAX_WIDTH),
        .MAX_HEIGHT     (MAX_HEIGHT),
        .NUM_COMPONENTS (NUM_COMPONENTS)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .cmd         (cmd),
        .picture     (picture),
        .component   (component),
        .row         (row),
        .col         (col),
        .pixel_value (pixel_value),
        .residue     (residue),
        .mv_prev_y   (mv_prev_y),
        .mv_prev_x   (mv_prev_x),
        .mv_next_y   (mv_next_y),
        .mv_next_x   (mv_next_x),
        .dp_cmd      (dp_cmd),
        .status      (dp_status),
        .read_value  (read_value),
        .prev_new    (prev_new),
        .next_new    (next_new)
    );

`ifndef ASSERT_OFF
    // An accepted transaction makes the block busy on the next cycle.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input accepted while previous transaction in flight");

    // Address calculation directly follows acceptance.
    a_calc_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> dp_cmd.calc)
        else $error("address stage skipped after acceptance");

    // Results only move into a free or draining output register.
    a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        dp_cmd.load_out |-> (!out_valid || out_ready))
        else $error("output register overwritten before transaction");

    // At most one source drives the memory write port.
    a_one_writer: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({dp_cmd.mem_write, dp_cmd.mid, dp_cmd.wr_next}))
        else $error("conflicting memory writes");
`endif

endmodule

### test/mctf_update_checker.sv
`timescale 1ns / 1ps
// Checker that predicts and compares every result of the motion-compensated update block.
module mctf_update_checker (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_valid,
    input  logic              cfg_ready,
    input  logic [1:0]        cfg_index,
    input  logic [8:0]        cfg_data,
    input  logic              in_valid,
    input  logic              in_ready,
    input  logic [1:0]        cmd,
    input  logic              picture,
    input  logic [1:0]        component,
    input  logic [6:0]        row,
    input  logic [6:0]        col,
    input  logic [7:0]        pixel_value,
    input  logic signed [8:0] residue,
    input  logic signed [7:0] mv_prev_y,
    input  logic signed [7:0] mv_prev_x,
    input  logic signed [7:0] mv_next_y,
    input  logic signed [7:0] mv_next_x,
    input  logic              out_valid,
    input  logic              out_ready,
    input  logic [7:0]        read_value,
    input  logic [7:0]        prev_new,
    input  logic [7:0]        next_new,
    output int                errors,
    output int                outstanding,
    output int                checked
);
    import mcu_pkg::*;

    localparam int FRAME_W = 128;
    localparam int FRAME_H = 128;
    localparam int PLANES  = 3;
    localparam int SUM_TOP = 255 * 256;

    typedef struct packed {
        logic [7:0] read_value;
        logic [7:0] prev_new;
        logic [7:0] next_new;
    } pel_result_t;

    // Private copy of both reference pictures and of the register file.
    logic [7:0]  frame_mem [0:2*PLANES*FRAME_H*FRAME_W-1];
    logic [7:0]  width_reg;
    logic [7:0]  height_reg;
    logic [8:0]  weight_reg;
    logic        add_reg;
    pel_result_t pending_q [$];

    // Usable frame size: zero acts as one, anything above the maximum is capped.
    function automatic int span(input logic [7:0] raw, input int limit);
        int v;
        v = int'(raw);
        if (v == 0)
            v = 1;
        if (v > limit)
            v = limit;
        return v;
    endfunction

    function automatic int clip(input int v, input int dim);
        if (v < 0)
            return 0;
        if (v >= dim)
            return dim - 1;
        return v;
    endfunction

    function automatic int unsigned pel_index(input logic pic, input logic [1:0] plane,
                                              input int y, input int x);
        return ((int'(pic) * PLANES + int'(plane)) * FRAME_H + y) * FRAME_W + x;
    endfunction

    // Weighted residue applied to one pixel, saturated and truncated back to 8 bits.
    function automatic logic [7:0] blend(input logic [7:0] pel, input logic signed [8:0] res);
        int s;
        int d;
        s = int'(pel) * 256;
        d = int'(res) * int'(weight_reg);
        s = add_reg ? s + d : s - d;
        if (s < 0)
            s = 0;
        if (s > SUM_TOP)
            s = SUM_TOP;
        return s[15:8];
    endfunction

    // Carries out the command on the input ports and returns the result it should give.
    function automatic pel_result_t apply_command();
        int w;
        int h;
        int y;
        int x;
        int unsigned a;
        pel_result_t r;
        r = '0;
        w = span(width_reg, FRAME_W);
        h = span(height_reg, FRAME_H);
        case (cmd)
            OP_WRITE:
            begin
                if (int'(component) < PLANES && int'(row) < h && int'(col) < w)
                    frame_mem[pel_index(picture, component, row, col)] = pixel_value;
            end
            OP_READ:
            begin
                if (int'(component) < PLANES && int'(row) < h && int'(col) < w)
                    r.read_value = frame_mem[pel_index(picture, component, row, col)];
            end
            OP_UPDATE:
            begin
                if (int'(component) < PLANES)
                begin
                    // The previous picture is updated first, then the next one.
                    y = clip(int'(row) + int'(mv_prev_y), h);
                    x = clip(int'(col) + int'(mv_prev_x), w);
                    a = pel_index(1'b0, component, y, x);
                    frame_mem[a] = blend(frame_mem[a], residue);
                    r.prev_new = frame_mem[a];
                    y = clip(int'(row) + int'(mv_next_y), h);
                    x = clip(int'(col) + int'(mv_next_x), w);
                    a = pel_index(1'b1, component, y, x);
                    frame_mem[a] = blend(frame_mem[a], residue);
                    r.next_new = frame_mem[a];
                end
            end
            default:
            begin
            end
        endcase
        return r;
    endfunction

    task automatic check_field(input string field, input logic [7:0] want,
                               input logic [7:0] got);
        if (got !== want)
        begin
            errors++;
            $display("%0t: %s expected %0d, got %0d", $time, field, want, got);
        end
    endtask

    // Watch the three channels at each rising edge.
    always @(posedge clk or negedge rst_n)
    begin
        pel_result_t want;
        if (!rst_n)
        begin
            width_reg   = RST_WIDTH;
            height_reg  = RST_HEIGHT;
            weight_reg  = RST_WEIGHT;
            add_reg     = RST_ADD_MODE;
            errors      = 0;
            checked     = 0;
            outstanding = 0;
            pending_q.delete();
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_WIDTH:    width_reg  = cfg_data[7:0];
                    CFG_HEIGHT:   height_reg = cfg_data[7:0];
                    CFG_WEIGHT:   weight_reg = cfg_data;
                    CFG_ADD_MODE: add_reg    = cfg_data[0];
                    default:      ;
                endcase
            end
            if (out_valid && out_ready)
            begin
                if (pending_q.size() == 0)
                begin
                    errors++;
                    $display("%0t: result transaction with no command pending (%0d %0d %0d)",
                             $time, read_value, prev_new, next_new);
                end
                else
                begin
                    want = pending_q.pop_front();
                    check_field("read_value", want.read_value, read_value);
                    check_field("prev_new", want.prev_new, prev_new);
                    check_field("next_new", want.next_new, next_new);
                    checked++;
                end
            end
            if (in_valid && in_ready)
                pending_q.push_back(apply_command());
            outstanding = pending_q.size();
        end
    end

endmodule

### test/testbench.sv
`timescale 1ns / 1ps
// Top of the testbench: clock, reset, command and register stimulus, and the verdict.
module testbench;
    import mcu_pkg::*;

    localparam int RUN_LIMIT = 1_000_000;
    localparam int FRAME_W   = 128;
    localparam int FRAME_H   = 128;
    localparam int PLANES    = 3;
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    typedef struct {
        logic [1:0]        cmd;
        logic              picture;
        logic [1:0]        component;
        logic [6:0]        row;
        logic [6:0]        col;
        logic [7:0]        pixel_value;
        logic signed [8:0] residue;
        logic signed [7:0] mv_prev_y;
        logic signed [7:0] mv_prev_x;
        logic signed [7:0] mv_next_y;
        logic signed [7:0] mv_next_x;
    } command_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic [1:0]        cfg_index = CFG_WIDTH;
    logic [8:0]        cfg_data = '0;
    logic              in_valid = 1'b0;
    logic              in_ready;
    logic [1:0]        cmd = OP_WRITE;
    logic              picture = 1'b0;
    logic [1:0]        component = '0;
    logic [6:0]        row = '0;
    logic [6:0]        col = '0;
    logic [7:0]        pixel_value = '0;
    logic signed [8:0] residue = '0;
    logic signed [7:0] mv_prev_y = '0;
    logic signed [7:0] mv_prev_x = '0;
    logic signed [7:0] mv_next_y = '0;
    logic signed [7:0] mv_next_x = '0;
    logic              out_valid;
    logic              out_ready = 1'b1;
    logic [7:0]        read_value;
    logic [7:0]        prev_new;
    logic [7:0]        next_new;
    int                errors;
    int                outstanding;
    int                checked;

    // Stimulus bookkeeping: frame size in use and which pixels hold data.
    logic [7:0] width_raw = RST_WIDTH;
    logic [7:0] height_raw = RST_HEIGHT;
    bit         loaded [0:2*PLANES*FRAME_H*FRAME_W-1];
    bit         calm = 1'b0;
    bit         gappy = 1'b0;
    int         ready_run = 0;
    int         cycle_count = 0;
    int         n_write = 0;
    int         n_update = 0;
    int         n_read = 0;
    int         n_odd = 0;
    int         n_settings = 0;

    mctf_motion_compensated_update i_dut (.*);

    mctf_update_checker i_checker (.*);

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Receiver stalls in random bursts, none in the closing part.
    always @(negedge clk)
    begin
        if (calm)
            out_ready <= 1'b1;
        else if (ready_run > 0)
            ready_run <= ready_run - 1;
        else if (out_ready)
        begin
            if ($urandom_range(0, 2) == 0)
            begin
                out_ready <= 1'b0;
                ready_run <= $urandom_range(0, 13);
            end
            else
                ready_run <= $urandom_range(1, 40);
        end
        else
        begin
            out_ready <= 1'b1;
            ready_run <= $urandom_range(0, 60);
        end
    end

    // Watchdog on the whole run.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == RUN_LIMIT)
        begin
            $display("Timed out after %0d cycles with %0d results outstanding.",
                     cycle_count, outstanding);
            $display("FAIL mctf_motion_compensated_update");
            $finish;
        end
    end

    function automatic int extent(input logic [7:0] raw, input int limit);
        int v;
        v = int'(raw);
        if (v == 0)
            v = 1;
        if (v > limit)
            v = limit;
        return v;
    endfunction

    function automatic int pin(input int v, input int dim);
        if (v < 0)
            return 0;
        if (v >= dim)
            return dim - 1;
        return v;
    endfunction

    function automatic int unsigned slot(input logic pic, input logic [1:0] plane,
                                         input int y, input int x);
        return ((int'(pic) * PLANES + int'(plane)) * FRAME_H + y) * FRAME_W + x;
    endfunction

    function automatic command_t make(input logic [1:0] op, input logic pic,
                                      input logic [1:0] plane, input int y, input int x,
                                      input logic [7:0] pel, input logic signed [8:0] res,
                                      input logic signed [7:0] py, input logic signed [7:0] px,
                                      input logic signed [7:0] ny, input logic signed [7:0] nx);
        command_t c;
        c.cmd         = op;
        c.picture     = pic;
        c.component   = plane;
        c.row         = y;
        c.col         = x;
        c.pixel_value = pel;
        c.residue     = res;
        c.mv_prev_y   = py;
        c.mv_prev_x   = px;
        c.mv_next_y   = ny;
        c.mv_next_x   = nx;
        return c;
    endfunction

    // Positions lean toward the frame in use and a small corner region for reuse.
    function automatic logic [6:0] pick_pos(input int dim);
        case ($urandom_range(0, 3))
            0:       return $urandom_range(0, 127);
            1:       return $urandom_range(0, (dim < 8 ? dim : 8) - 1);
            default: return $urandom_range(0, dim - 1);
        endcase
    endfunction

    function automatic logic signed [7:0] pick_mv();
        int k;
        k = $urandom_range(0, 9);
        if (k < 7)
            return int'($urandom_range(0, 6)) - 3;
        if (k < 9)
            return $urandom;
        return $urandom_range(0, 1) ? 8'h80 : 8'h7F;
    endfunction

    function automatic logic signed [8:0] pick_residue();
        case ($urandom_range(0, 4))
            3:       return int'($urandom_range(0, 16)) - 8;
            4:       return $urandom_range(0, 1) ? 9'h100 : 9'h0FF;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [7:0] pick_pixel();
        if ($urandom_range(0, 9) < 7)
            return $urandom;
        return $urandom_range(0, 1) ? 8'hFF : 8'h00;
    endfunction

    function automatic command_t random_command();
        int w;
        int h;
        int k;
        command_t c;
        w = extent(width_raw, FRAME_W);
        h = extent(height_raw, FRAME_H);
        c = make(OP_WRITE, $urandom_range(0, 1), $urandom_range(0, PLANES - 1),
                 pick_pos(h), pick_pos(w), pick_pixel(), pick_residue(),
                 pick_mv(), pick_mv(), pick_mv(), pick_mv());
        k = $urandom_range(0, 99);
        if (k < 25)
            c.cmd = OP_WRITE;
        else if (k < 70)
            c.cmd = OP_UPDATE;
        else if (k < 92)
            c.cmd = OP_READ;
        else if ($urandom_range(0, 1) == 0)
        begin
            c.cmd = CMD_UNUSED;
            c.component = $urandom_range(0, 3);
        end
        else
        begin
            // Out-of-range plane on a regular command.
            case ($urandom_range(0, 2))
                0:       c.cmd = OP_WRITE;
                1:       c.cmd = OP_UPDATE;
                default: c.cmd = OP_READ;
            endcase
            c.component = 2'd3;
        end
        return c;
    endfunction

    // One input transaction, with an optional sender gap in front of it.
    task automatic drive(input command_t c);
        int w;
        int h;
        w = extent(width_raw, FRAME_W);
        h = extent(height_raw, FRAME_H);
        if (!calm && gappy && $urandom_range(0, 2) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(negedge clk);
        end
        in_valid    <= 1'b1;
        cmd         <= c.cmd;
        picture     <= c.picture;
        component   <= c.component;
        row         <= c.row;
        col         <= c.col;
        pixel_value <= c.pixel_value;
        residue     <= c.residue;
        mv_prev_y   <= c.mv_prev_y;
        mv_prev_x   <= c.mv_prev_x;
        mv_next_y   <= c.mv_next_y;
        mv_next_x   <= c.mv_next_x;
        if (c.cmd == CMD_UNUSED || int'(c.component) >= PLANES)
            n_odd++;
        else if (c.cmd == OP_WRITE)
        begin
            n_write++;
            if (int'(c.row) < h && int'(c.col) < w)
                loaded[slot(c.picture, c.component, c.row, c.col)] = 1'b1;
        end
        else if (c.cmd == OP_UPDATE)
            n_update++;
        else
            n_read++;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Loads a pixel that has never been written before anything reads it.
    task automatic fill(input logic pic, input logic [1:0] plane, input int y, input int x);
        if (!loaded[slot(pic, plane, y, x)])
            drive(make(OP_WRITE, pic, plane, y, x, pick_pixel(), '0, '0, '0, '0, '0));
    endtask

    task automatic issue(input command_t c);
        int w;
        int h;
        w = extent(width_raw, FRAME_W);
        h = extent(height_raw, FRAME_H);
        if (int'(c.component) < PLANES)
        begin
            if (c.cmd == OP_READ && int'(c.row) < h && int'(c.col) < w)
                fill(c.picture, c.component, c.row, c.col);
            if (c.cmd == OP_UPDATE)
            begin
                fill(1'b0, c.component, pin(int'(c.row) + int'(c.mv_prev_y), h),
                     pin(int'(c.col) + int'(c.mv_prev_x), w));
                fill(1'b1, c.component, pin(int'(c.row) + int'(c.mv_next_y), h),
                     pin(int'(c.col) + int'(c.mv_next_x), w));
            end
        end
        drive(c);
    endtask

    // Drops the input valid and waits for every outstanding result.
    task automatic settle();
        in_valid <= 1'b0;
        while (outstanding != 0)
            @(negedge clk);
    endtask

    task automatic put_reg(input cfg_idx_t idx, input logic [8:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Writes all four registers back to back; only called with the block idle.
    task automatic configure(input logic [8:0] w, input logic [8:0] h, input logic [8:0] wt,
                             input logic [8:0] am);
        put_reg(CFG_WIDTH, w);
        put_reg(CFG_HEIGHT, h);
        put_reg(CFG_WEIGHT, wt);
        put_reg(CFG_ADD_MODE, am);
        cfg_valid  <= 1'b0;
        width_raw  = w[7:0];
        height_raw = h[7:0];
        n_settings++;
    endtask

    task automatic run_phase(input int count);
        for (int i = 0; i < count; i++)
        begin
            if (i % 40 == 0)
                gappy = ($urandom_range(0, 3) != 0);
            issue(random_command());
        end
        settle();
    endtask

    initial
    begin
        repeat (9) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed part under the reset settings: corners, saturation both ways,
        // clamped motion, an invalid plane and the unused command.
        n_settings = 1;
        issue(make(OP_WRITE, 1'b0, 2'd0, 0, 0, 8'h00, '0, '0, '0, '0, '0));
        issue(make(OP_WRITE, 1'b1, 2'd0, 0, 0, 8'hFF, '0, '0, '0, '0, '0));
        issue(make(OP_WRITE, 1'b0, 2'd2, 127, 127, 8'hFF, '0, '0, '0, '0, '0));
        issue(make(OP_WRITE, 1'b1, 2'd2, 127, 127, 8'h00, '0, '0, '0, '0, '0));
        issue(make(OP_READ, 1'b0, 2'd0, 0, 0, '0, '0, '0, '0, '0, '0));
        issue(make(OP_READ, 1'b1, 2'd2, 127, 127, '0, '0, '0, '0, '0, '0));
        issue(make(OP_UPDATE, 1'b0, 2'd0, 0, 0, '0, 9'sd255,
                   8'h80, 8'h80, 8'h80, 8'h80));
        issue(make(OP_UPDATE, 1'b1, 2'd0, 0, 0, '0, 9'h100, '0, '0, '0, '0));
        issue(make(OP_UPDATE, 1'b0, 2'd2, 127, 127, '0, 9'h100,
                   8'h7F, 8'h7F, 8'h7F, 8'h7F));
        issue(make(OP_UPDATE, 1'b1, 2'd2, 127, 127, '0, 9'sd255,
                   8'h7F, 8'h7F, 8'h7F, 8'h7F));
        issue(make(OP_UPDATE, 1'b0, 2'd1, 0, 127, '0, 9'sd100,
                   8'h80, 8'h7F, 8'h7F, 8'h80));
        issue(make(OP_WRITE, 1'b1, 2'd3, 5, 5, 8'hAA, '0, '0, '0, '0, '0));
        issue(make(OP_READ, 1'b1, 2'd3, 5, 5, '0, '0, '0, '0, '0, '0));
        issue(make(OP_UPDATE, 1'b0, 2'd3, 5, 5, '0, 9'h155,
                   8'h55, 8'hAA, 8'h55, 8'hAA));
        issue(make(CMD_UNUSED, 1'b1, 2'd3, 127, 127, 8'hFF, 9'h1FF,
                   8'hFF, 8'hFF, 8'hFF, 8'hFF));
        issue(make(OP_READ, 1'b0, 2'd0, 0, 0, '0, '0, '0, '0, '0, '0));
        issue(make(OP_READ, 1'b1, 2'd0, 0, 0, '0, '0, '0, '0, '0, '0));
        issue(make(OP_READ, 1'b0, 2'd2, 127, 127, '0, '0, '0, '0, '0, '0));
        issue(make(OP_READ, 1'b1, 2'd2, 127, 127, '0, '0, '0, '0, '0, '0));
        settle();

        // Random part over a series of register settings, extremes first.
        configure(9'd1, 9'd1, 9'd256, 9'd1);
        run_phase(75);
        configure(9'd12, 9'd9, 9'd511, 9'd0);
        run_phase(100);
        configure(9'd0, 9'd0, 9'd0, 9'd1);
        run_phase(50);
        configure(9'd255, 9'd200, 9'd64, 9'd0);
        run_phase(125);
        configure(9'd128, 9'd128, $urandom_range(0, 511), 9'd1);
        run_phase(100);
        repeat (3)
        begin
            configure($urandom_range(1, 40), $urandom_range(1, 40), $urandom_range(0, 511),
                      $urandom_range(0, 1));
            run_phase(75);
        end

        // Closing part at full rate on both sides.
        configure(9'd8, 9'd8, 9'd128, 9'd0);
        calm = 1'b1;
        run_phase(100);
        repeat (16) @(negedge clk);

        $display("Ran %0d writes, %0d updates, %0d reads and %0d unused or bad-plane commands",
                 n_write, n_update, n_read, n_odd);
        $display("over %0d register settings; %0d results compared.", n_settings, checked);
        if (errors == 0)
            $display("PASS mctf_motion_compensated_update");
        else
            $display("FAIL mctf_motion_compensated_update");
        $finish;
    end

endmodule
